// ===== hw/rtl/iir_biquad_offset_removal_unit_macros.svh =====
// Assertion macros for the biquad filter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef IIR_BIQUAD_OFFSET_REMOVAL_UNIT_MACROS_SVH
`define IIR_BIQUAD_OFFSET_REMOVAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IIRBQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iirbq assertion failed");
`define IIRBQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("iirbq assertion failed");
`else
`define IIRBQ_ASSERT(lbl, clk, rst_n, prop)
`define IIRBQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/iirbq_pkg.sv =====
// Types and constants of the biquad filter with offset removal.
// No dependencies; used by the datapath and the top level.
package iirbq_pkg;

  localparam int SampleW  = 16;
  localparam int CoefW    = 18;
  localparam int XW       = 17;
  localparam int YW       = 20;
  localparam int FracBits = 14;
  localparam int AccW     = 41;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;
  localparam int ModeW    = 2;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [XW-1:0]      x_t;
  typedef logic signed [YW-1:0]      y_t;

  localparam logic [ModeW-1:0] ModeRaw     = 2'd0;
  localparam logic [ModeW-1:0] ModeRestore = 2'd1;

  typedef enum logic [2:0] {
    RegB0   = 3'd0,
    RegB1   = 3'd1,
    RegB2   = 3'd2,
    RegA1   = 3'd3,
    RegA2   = 3'd4,
    RegMode = 3'd5
  } reg_idx_e;

  localparam coef_t ResetB0 = 18'sd16384;

  typedef struct packed {
    coef_t            b0;
    coef_t            b1;
    coef_t            b2;
    coef_t            a1;
    coef_t            a2;
    logic [ModeW-1:0] mode;
  } cfg_t;

  typedef struct packed {
    x_t      x1;
    x_t      x2;
    y_t      y1;
    y_t      y2;
    sample_t offset;
  } hist_t;

  typedef struct packed {
    sample_t filtered;
    logic    clipped;
    x_t      x;
    y_t      y;
    sample_t offset;
  } res_t;

endpackage

// ===== hw/rtl/iirbq_datapath.sv =====
// Combinational biquad step: offset handling, five taps, rounding and saturation.
// Depends on iirbq_pkg.
module iirbq_datapath (
  input  iirbq_pkg::cfg_t    cfg_i,
  input  iirbq_pkg::hist_t   hist_i,
  input  iirbq_pkg::sample_t sample_i,
  input  logic               first_i,
  output iirbq_pkg::res_t    res_o
);
  import iirbq_pkg::*;

  localparam int PxW = CoefW + XW;
  localparam int PyW = CoefW + YW;
  localparam int YwW = AccW - FracBits;
  localparam int RW  = YW + 1;

  sample_t               offset_cur;
  x_t                    s_ext;
  x_t                    o_ext;
  x_t                    x;
  logic signed [PxW-1:0] p0, p1, p2;
  logic signed [PyW-1:0] q1, q2;
  logic signed [AccW-1:0] acc;
  logic signed [YwW-1:0] yw;
  logic                  y_fits;
  y_t                    y;
  logic signed [RW-1:0]  r;
  logic                  r_fits;
  sample_t               filtered;

  assign offset_cur = first_i ? sample_i : hist_i.offset;
  assign s_ext      = {sample_i[SampleW-1], sample_i};
  assign o_ext      = {offset_cur[SampleW-1], offset_cur};
  assign x          = (cfg_i.mode == ModeRaw) ? s_ext : (s_ext - o_ext);

  assign p0 = cfg_i.b0 * x;
  assign p1 = cfg_i.b1 * hist_i.x1;
  assign p2 = cfg_i.b2 * hist_i.x2;
  assign q1 = cfg_i.a1 * hist_i.y1;
  assign q2 = cfg_i.a2 * hist_i.y2;

  assign acc = AccW'(p0) + AccW'(p1) + AccW'(p2) - AccW'(q1) - AccW'(q2)
             + AccW'(1 << (FracBits - 1));

  assign yw     = $signed(acc[AccW-1:FracBits]);
  assign y_fits = (yw[YwW-1:YW-1] == '0) || (yw[YwW-1:YW-1] == '1);

  always_comb begin
    if (y_fits) begin
      y = yw[YW-1:0];
    end else if (yw[YwW-1]) begin
      y = {1'b1, {(YW-1){1'b0}}};
    end else begin
      y = {1'b0, {(YW-1){1'b1}}};
    end
  end

  assign r = (cfg_i.mode == ModeRestore)
           ? ({y[YW-1], y} + RW'(offset_cur))
           : {y[YW-1], y};
  assign r_fits = (r[RW-1:SampleW-1] == '0) || (r[RW-1:SampleW-1] == '1);

  always_comb begin
    if (r_fits) begin
      filtered = r[SampleW-1:0];
    end else if (r[RW-1]) begin
      filtered = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      filtered = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  assign res_o.filtered = filtered;
  assign res_o.clipped  = !y_fits || !r_fits;
  assign res_o.x        = x;
  assign res_o.y        = y;
  assign res_o.offset   = offset_cur;

endmodule

// ===== hw/rtl/iir_biquad_offset_removal_unit.sv =====
// Second-order direct-form-I IIR filter with captured offset removal.
// Depends on iirbq_pkg, iirbq_datapath and the assertion macro header.
//
// Input channel: sample_i and first_i with in_valid_i; the block holds off with
// in_stall_o. A request with first_i high stores its sample as the offset
// before it is filtered.
// Output channel: filtered_o and clipped_o with out_valid_o; the receiver holds
// a result with out_stall_i, and it stays on the ports until it is taken.
// Coefficients and the offset mode are written over the APB-style port; the user
// must write them only while the block is idle, as the block does not enforce it.
// pready is always high and reads return the registers. An accepted request
// waits in the input register while the filter arithmetic feeds the result register.
// Throughput is one request per cycle while the receiver does not stall, set by the
// loop from the stored output history through the five multipliers and the adder
// tree back into history. While the receiver stalls, the input register fills and
// then in_stall_o rises; nothing is lost. Reset clears the histories, the offset,
// the valid flags and loads the default coefficients (unity b0, all others zero).
`include "iir_biquad_offset_removal_unit_macros.svh"

module iir_biquad_offset_removal_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iirbq_pkg::AddrW-1:0]         paddr,
  input  logic [iirbq_pkg::DataW-1:0]         pwdata,
  output logic [iirbq_pkg::DataW-1:0]         prdata,
  output logic                                pready,
  input  iirbq_pkg::sample_t                  sample_i,
  input  logic                                first_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  output iirbq_pkg::sample_t                  filtered_o,
  output logic                                clipped_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i
);
  import iirbq_pkg::*;

  cfg_t     cfg_q;
  hist_t    hist_q, hist_d;
  res_t     res;
  sample_t  s1_sample_q;
  logic     s1_first_q;
  logic     s1_valid_q;
  sample_t  filtered_q;
  logic     clipped_q;
  logic     out_valid_q;
  logic     adv;
  logic     hist_en;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0   <= ResetB0;
      cfg_q.b1   <= '0;
      cfg_q.b2   <= '0;
      cfg_q.a1   <= '0;
      cfg_q.a2   <= '0;
      cfg_q.mode <= ModeRaw;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegB0:   cfg_q.b0   <= $signed(pwdata[CoefW-1:0]);
        RegB1:   cfg_q.b1   <= $signed(pwdata[CoefW-1:0]);
        RegB2:   cfg_q.b2   <= $signed(pwdata[CoefW-1:0]);
        RegA1:   cfg_q.a1   <= $signed(pwdata[CoefW-1:0]);
        RegA2:   cfg_q.a2   <= $signed(pwdata[CoefW-1:0]);
        RegMode: cfg_q.mode <= pwdata[ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegB0:   prdata = DataW'(cfg_q.b0);
      RegB1:   prdata = DataW'(cfg_q.b1);
      RegB2:   prdata = DataW'(cfg_q.b2);
      RegA1:   prdata = DataW'(cfg_q.a1);
      RegA2:   prdata = DataW'(cfg_q.a2);
      RegMode: prdata = DataW'(cfg_q.mode);
      default: prdata = '0;
    endcase
  end

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign hist_en    = adv && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_sample_q <= sample_i;
      s1_first_q  <= first_i;
    end
  end

  iirbq_datapath u_datapath (
    .cfg_i    (cfg_q),
    .hist_i   (hist_q),
    .sample_i (s1_sample_q),
    .first_i  (s1_first_q),
    .res_o    (res)
  );

  always_comb begin
    hist_d        = hist_q;
    hist_d.x1     = res.x;
    hist_d.x2     = hist_q.x1;
    hist_d.y1     = res.y;
    hist_d.y2     = hist_q.y1;
    hist_d.offset = res.offset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (hist_en) begin
      hist_q <= hist_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_en) begin
      filtered_q <= res.filtered;
      clipped_q  <= res.clipped;
    end
  end

  assign filtered_o  = filtered_q;
  assign clipped_o   = clipped_q;
  assign out_valid_o = out_valid_q;

  `IIRBQ_ASSERT(a_stall_needs_item, clk_i, rst_ni, in_stall_o |-> s1_valid_q && out_valid_q)
  `IIRBQ_ASSERT(a_hist_holds, clk_i, rst_ni, !hist_en |=> $stable(hist_q))
  `IIRBQ_ASSERT(a_result_from_item, clk_i, rst_ni, $rose(out_valid_q) |-> $past(s1_valid_q))

endmodule
